FILE: sv/dopr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest packet ring package
// Sizes, codes and beat types shared by the ring's front, queue, back and
// checker.
// ----------------------------------------------------------------------------
package dopr_pkg;

	localparam int SLOTS       = 64;
	localparam int MAX_BYTES   = 1275;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int LEN_W       = 11;
	localparam int TS_W        = 64;
	localparam int DROP_W      = 32;
	localparam int BYTES_DEPTH = SLOTS * MAX_BYTES;
	localparam int ADDR_W      = $clog2(BYTES_DEPTH);
	localparam int LAST_BASE   = (SLOTS - 1) * MAX_BYTES;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_HDR  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_POP  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LEN_REJ  = 3'd1,
		ST_BYTE_IGN = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_HDR,
		OP_HDR_BAD,
		OP_DATA,
		OP_PEEK,
		OP_POP
	} op_t;

	typedef enum logic {
		BK_EXEC,
		BK_READ
	} bk_state_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [LEN_W-1:0] packet_length;
		logic [TS_W-1:0]  timestamp_us;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] byte_offset;
	} cmd_beat_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              dropped_oldest;
		logic [7:0]        read_byte;
		logic [LEN_W-1:0]  out_length;
		logic [TS_W-1:0]   out_timestamp_us;
		logic [DROP_W-1:0] drop_count;
		logic [CNT_W-1:0]  queued;
	} rsp_beat_t;

	typedef struct packed {
		op_t              op;
		logic [LEN_W-1:0] packet_length;
		logic [TS_W-1:0]  timestamp_us;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] byte_offset;
	} qent_t;

endpackage
`default_nettype wire

FILE: sv/dopr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest packet ring front end
// Accepts command beats and classifies each one into an operation for the
// back end, rejecting header lengths that are zero or too large.
// ----------------------------------------------------------------------------
module dopr_front (
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire dopr_pkg::cmd_beat_t cmd,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output dopr_pkg::qent_t        q_entry
);
	import dopr_pkg::*;

	logic len_bad;

	assign len_bad   = (cmd.packet_length == '0) || (cmd.packet_length > LEN_W'(MAX_BYTES));
	assign cmd_ready = q_ready;
	assign q_valid   = cmd_valid;

	always_comb begin
		q_entry.packet_length = cmd.packet_length;
		q_entry.timestamp_us  = cmd.timestamp_us;
		q_entry.data_byte     = cmd.data_byte;
		q_entry.byte_offset   = cmd.byte_offset;
		unique case (cmd.kind)
			KIND_HDR: begin
				q_entry.op = len_bad ? OP_HDR_BAD : OP_HDR;
			end
			KIND_DATA: begin
				q_entry.op = OP_DATA;
			end
			KIND_PEEK: begin
				q_entry.op = OP_PEEK;
			end
			KIND_POP: begin
				q_entry.op = OP_POP;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/dopr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest packet ring operation queue
// A short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module dopr_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_valid,
	output logic                 wr_ready,
	input  wire dopr_pkg::qent_t wr_data,
	output logic                 rd_valid,
	input  wire logic            rd_ready,
	output dopr_pkg::qent_t      rd_data
);
	import dopr_pkg::*;

	qent_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != QCNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/dopr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest packet ring back end
// Carries out queued operations on the slot ring and its memories and holds
// the result beat in an output register.
// ----------------------------------------------------------------------------
module dopr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire dopr_pkg::qent_t q_entry,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output dopr_pkg::rsp_beat_t  rsp
);
	import dopr_pkg::*;

	logic [7:0]       bytes_mem [BYTES_DEPTH];
	logic [LEN_W-1:0] len_mem   [SLOTS];
	logic [TS_W-1:0]  ts_mem    [SLOTS];

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [SLOT_W-1:0] wr_slot_q;
	logic [SLOT_W-1:0] wr_slot_d;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [SLOT_W-1:0] rd_slot_d;
	logic [ADDR_W-1:0] wr_base_q;
	logic [ADDR_W-1:0] wr_base_d;
	logic [ADDR_W-1:0] rd_base_q;
	logic [ADDR_W-1:0] rd_base_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [LEN_W-1:0]  fill_off_q;
	logic [LEN_W-1:0]  fill_off_d;
	logic              filling_q;
	logic              filling_d;
	logic [DROP_W-1:0] drop_q;
	logic [DROP_W-1:0] drop_d;
	logic [LEN_W-1:0]  cur_len_q;
	logic              pend_pop_q;
	logic [LEN_W-1:0]  pend_off_q;
	logic              out_valid_q;
	rsp_beat_t         out_q;
	rsp_beat_t         out_d;

	logic [7:0]        byte_rd_q;
	logic [LEN_W-1:0]  len_rd_q;
	logic [TS_W-1:0]   ts_rd_q;

	logic              out_free;
	logic              take;
	logic              is_read_op;
	logic              load;
	logic              rd_en;
	logic              byte_we;
	logic              meta_we;
	logic [LEN_W-1:0]  fill_inc;
	logic [ADDR_W-1:0] byte_wr_addr;
	logic [ADDR_W-1:0] byte_rd_addr;

	assign out_free     = !out_valid_q || rsp_ready;
	assign is_read_op   = (q_entry.op == OP_PEEK) || (q_entry.op == OP_POP);
	assign take         = (state_q == BK_EXEC) && q_valid && out_free;
	assign q_ready      = take;
	assign rsp_valid    = out_valid_q;
	assign rsp          = out_q;
	assign fill_inc     = fill_off_q + LEN_W'(1);
	assign byte_wr_addr = ADDR_W'(wr_base_q + ADDR_W'(fill_off_q));
	assign byte_rd_addr = ADDR_W'(rd_base_q + ADDR_W'(q_entry.byte_offset));

	always_comb begin
		unique case (state_q)
			BK_EXEC: begin
				state_d = (take && is_read_op && (count_q != '0)) ? BK_READ : BK_EXEC;
			end
			BK_READ: begin
				state_d = out_free ? BK_EXEC : BK_READ;
			end
			default: begin
				state_d = BK_EXEC;
			end
		endcase
	end

	always_comb begin
		wr_slot_d  = wr_slot_q;
		rd_slot_d  = rd_slot_q;
		wr_base_d  = wr_base_q;
		rd_base_d  = rd_base_q;
		count_d    = count_q;
		fill_off_d = fill_off_q;
		filling_d  = filling_q;
		drop_d     = drop_q;
		load       = 1'b0;
		rd_en      = 1'b0;
		byte_we    = 1'b0;
		meta_we    = 1'b0;
		out_d      = '0;
		unique case (state_q)
			BK_EXEC: begin
				if (take) begin
					unique case (q_entry.op)
						OP_HDR_BAD: begin
							load         = 1'b1;
							out_d.status = ST_LEN_REJ;
						end
						OP_HDR: begin
							load    = 1'b1;
							meta_we = 1'b1;
							if (count_q == CNT_W'(SLOTS)) begin
								rd_slot_d = (rd_slot_q == SLOT_W'(SLOTS - 1)) ? '0
									: rd_slot_q + 1'b1;
								rd_base_d = (rd_base_q == ADDR_W'(LAST_BASE)) ? '0
									: rd_base_q + ADDR_W'(MAX_BYTES);
								count_d   = count_q - 1'b1;
								if (drop_q != '1) begin
									drop_d = drop_q + 1'b1;
								end
								out_d.dropped_oldest = 1'b1;
							end
							fill_off_d   = '0;
							filling_d    = 1'b1;
							out_d.status = ST_OK;
						end
						OP_DATA: begin
							load = 1'b1;
							if (!filling_q || (fill_off_q >= LEN_W'(MAX_BYTES))) begin
								out_d.status = ST_BYTE_IGN;
							end else begin
								byte_we      = 1'b1;
								out_d.status = ST_OK;
								if (fill_inc >= cur_len_q) begin
									wr_slot_d  = (wr_slot_q == SLOT_W'(SLOTS - 1)) ? '0
										: wr_slot_q + 1'b1;
									wr_base_d  = (wr_base_q == ADDR_W'(LAST_BASE)) ? '0
										: wr_base_q + ADDR_W'(MAX_BYTES);
									count_d    = count_q + 1'b1;
									filling_d  = 1'b0;
									fill_off_d = '0;
								end else begin
									fill_off_d = fill_inc;
								end
							end
						end
						OP_PEEK, OP_POP: begin
							if (count_q == '0) begin
								load         = 1'b1;
								out_d.status = ST_EMPTY;
							end else begin
								rd_en = 1'b1;
								if (q_entry.op == OP_POP) begin
									rd_slot_d = (rd_slot_q == SLOT_W'(SLOTS - 1)) ? '0
										: rd_slot_q + 1'b1;
									rd_base_d = (rd_base_q == ADDR_W'(LAST_BASE)) ? '0
										: rd_base_q + ADDR_W'(MAX_BYTES);
									count_d   = count_q - 1'b1;
								end
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
					out_d.drop_count = drop_d;
					out_d.queued     = count_d;
				end
			end
			BK_READ: begin
				if (out_free) begin
					load             = 1'b1;
					out_d.out_length = len_rd_q;
					out_d.drop_count = drop_q;
					out_d.queued     = count_q;
					if (pend_pop_q) begin
						out_d.status           = ST_OK;
						out_d.out_timestamp_us = ts_rd_q;
					end else if ((pend_off_q >= len_rd_q)
						|| (pend_off_q >= LEN_W'(MAX_BYTES))) begin
						out_d.status = ST_RANGE;
					end else begin
						out_d.status    = ST_OK;
						out_d.read_byte = byte_rd_q;
					end
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (byte_we) begin
			bytes_mem[byte_wr_addr] <= q_entry.data_byte;
		end
		if (rd_en) begin
			byte_rd_q <= bytes_mem[byte_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			len_mem[wr_slot_q] <= q_entry.packet_length;
			ts_mem[wr_slot_q]  <= q_entry.timestamp_us;
		end
		if (rd_en) begin
			len_rd_q <= len_mem[rd_slot_q];
			ts_rd_q  <= ts_mem[rd_slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			cur_len_q <= q_entry.packet_length;
		end
		if (rd_en) begin
			pend_pop_q <= (q_entry.op == OP_POP);
			pend_off_q <= q_entry.byte_offset;
		end
		if (load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_EXEC;
			wr_slot_q   <= '0;
			rd_slot_q   <= '0;
			wr_base_q   <= '0;
			rd_base_q   <= '0;
			count_q     <= '0;
			fill_off_q  <= '0;
			filling_q   <= 1'b0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_slot_q  <= wr_slot_d;
			rd_slot_q  <= rd_slot_d;
			wr_base_q  <= wr_base_d;
			rd_base_q  <= rd_base_d;
			count_q    <= count_d;
			fill_off_q <= fill_off_d;
			filling_q  <= filling_d;
			drop_q     <= drop_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/drop_oldest_packet_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest packet ring
// Ring of packet slots that overwrites the oldest committed packet when full.
//
//   Channel   Signals                     Beat type
//   command   cmd_valid, cmd_ready, cmd   dopr_pkg::cmd_beat_t
//   response  rsp_valid, rsp_ready, rsp   dopr_pkg::rsp_beat_t
//
// Headers, data bytes, rejected headers and empty-ring requests load the result
// directly; peek and pop on a non-empty ring pass a read state that waits on the
// registered slot memory read. A two-beat queue sits between the front and back
// ends, so a command can be accepted while a result waits in the output register.
// Reset clears pointers, counters and flags only; slot memories need no clearing.
// ----------------------------------------------------------------------------
module drop_oldest_packet_ring (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire dopr_pkg::cmd_beat_t cmd,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output dopr_pkg::rsp_beat_t      rsp
);
	import dopr_pkg::*;

	logic  fq_valid;
	logic  fq_ready;
	qent_t fq_entry;
	logic  qb_valid;
	logic  qb_ready;
	qent_t qb_entry;

	dopr_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_entry   (fq_entry)
	);

	dopr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_entry),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_entry)
	);

	dopr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_entry   (qb_entry),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

FILE: sv/dopr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Drop-oldest packet ring checker
// Watches the ring's ports and checks outstanding results, counter behavior and stalls.
// ----------------------------------------------------------------------------
module dopr_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                cmd_valid,
	input wire logic                cmd_ready,
	input wire dopr_pkg::cmd_beat_t cmd,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire dopr_pkg::rsp_beat_t rsp
);
	import dopr_pkg::*;

	logic [DROP_W-1:0] last_drop_q;
	logic [CNT_W-1:0]  last_queued_q;
	logic [3:0]        pending_q;
	logic              cmd_fire;
	logic              rsp_fire;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_drop_q   <= '0;
			last_queued_q <= '0;
			pending_q     <= '0;
		end else begin
			if (rsp_fire) begin
				last_drop_q   <= rsp.drop_count;
				last_queued_q <= rsp.queued;
			end
			if (cmd_fire && !rsp_fire) begin
				pending_q <= pending_q + 1'b1;
			end else if (rsp_fire && !cmd_fire) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	// A result beat always answers a command that was accepted earlier.
	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pending_q != '0))
		else $error("result beat without an outstanding command");

	// The drop counter rises by one on a dropping header unless saturated, and otherwise holds.
	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_fire && rsp.dropped_oldest) |->
		((rsp.drop_count == last_drop_q + 1'b1) || (last_drop_q == '1)))
		else $error("drop counter did not advance on a dropped packet");

	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_fire && !rsp.dropped_oldest) |-> (rsp.drop_count == last_drop_q))
		else $error("drop counter changed without a drop");

	// The committed packet count moves by at most one between result beats.
	a_queued_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire |-> ((rsp.queued == last_queued_q)
		|| ({1'b0, rsp.queued} == {1'b0, last_queued_q} + 1'b1)
		|| ({1'b0, rsp.queued} + 1'b1 == {1'b0, last_queued_q})))
		else $error("queued count jumped by more than one");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result beat changed");

endmodule

bind drop_oldest_packet_ring dopr_checker u_dopr_checker (.*);
`default_nettype wire

FILE: test/tb_drop_oldest_packet_ring.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drop-oldest packet ring testbench
// Drives command beats into the ring and checks every response beat against a
// cycle-free model of the ring kept in the bench. Directed tests cover the
// rejected lengths, stray bytes, abandoned packets, empty-ring requests, a
// long packet, ring overflow and a long response stall; a random phase then
// mixes well-formed packets with peeks, pops and noise.
// ----------------------------------------------------------------------------
module tb_drop_oldest_packet_ring;
	import dopr_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_beat_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_beat_t rsp;

	drop_oldest_packet_ring uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [7:0]        slot_bytes [BYTES_DEPTH];
	logic [LEN_W-1:0]  slot_len [SLOTS];
	logic [TS_W-1:0]   slot_ts [SLOTS];
	int                wr_ptr = 0;
	int                rd_ptr = 0;
	int                held = 0;
	int                fill_pos = 0;
	bit                open_pkt = 1'b0;
	logic [DROP_W-1:0] drop_total = '0;

	rsp_beat_t pending_results [$];
	int        mismatches = 0;
	int        beats_sent = 0;
	bit        calm = 1'b0;
	int        hold_req = 0;
	int        hold_left = 0;

	function automatic int next_slot(int p);
		return (p == SLOTS - 1) ? 0 : p + 1;
	endfunction

	function automatic rsp_beat_t ring_predict(cmd_beat_t c);
		rsp_beat_t r;
		r = '0;
		case (c.kind)
		KIND_HDR: begin
			if (c.packet_length == 0 || c.packet_length > MAX_BYTES) begin
				r.status = ST_LEN_REJ;
			end else begin
				if (held >= SLOTS) begin
					rd_ptr = next_slot(rd_ptr);
					held--;
					if (drop_total != '1)
						drop_total++;
					r.dropped_oldest = 1'b1;
				end
				slot_len[wr_ptr] = c.packet_length;
				slot_ts[wr_ptr] = c.timestamp_us;
				fill_pos = 0;
				open_pkt = 1'b1;
			end
		end
		KIND_DATA: begin
			if (!open_pkt || fill_pos >= MAX_BYTES) begin
				r.status = ST_BYTE_IGN;
			end else begin
				slot_bytes[wr_ptr * MAX_BYTES + fill_pos] = c.data_byte;
				fill_pos++;
				if (fill_pos >= slot_len[wr_ptr]) begin
					wr_ptr = next_slot(wr_ptr);
					held++;
					open_pkt = 1'b0;
					fill_pos = 0;
				end
			end
		end
		default: begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else if (c.kind == KIND_PEEK) begin
				r.out_length = slot_len[rd_ptr];
				if (c.byte_offset >= slot_len[rd_ptr] || c.byte_offset >= MAX_BYTES)
					r.status = ST_RANGE;
				else
					r.read_byte = slot_bytes[rd_ptr * MAX_BYTES + c.byte_offset];
			end else begin
				r.out_length = slot_len[rd_ptr];
				r.out_timestamp_us = slot_ts[rd_ptr];
				rd_ptr = next_slot(rd_ptr);
				held--;
			end
		end
		endcase
		r.drop_count = drop_total;
		r.queued = CNT_W'(held);
		return r;
	endfunction

	function automatic cmd_beat_t rand_beat();
		cmd_beat_t b;
		b.kind = 2'($urandom_range(3));
		b.packet_length = LEN_W'($urandom_range(2047));
		b.timestamp_us = {$urandom(), $urandom()};
		b.data_byte = 8'($urandom_range(255));
		b.byte_offset = LEN_W'($urandom_range(2047));
		return b;
	endfunction

	function automatic cmd_beat_t hdr_beat(int len, logic [TS_W-1:0] ts);
		cmd_beat_t b;
		b = rand_beat();
		b.kind = KIND_HDR;
		b.packet_length = LEN_W'(len);
		b.timestamp_us = ts;
		return b;
	endfunction

	function automatic cmd_beat_t data_beat(logic [7:0] d);
		cmd_beat_t b;
		b = rand_beat();
		b.kind = KIND_DATA;
		b.data_byte = d;
		return b;
	endfunction

	function automatic cmd_beat_t peek_beat(int off);
		cmd_beat_t b;
		b = rand_beat();
		b.kind = KIND_PEEK;
		b.byte_offset = LEN_W'(off);
		return b;
	endfunction

	function automatic cmd_beat_t pop_beat();
		cmd_beat_t b;
		b = rand_beat();
		b.kind = KIND_POP;
		return b;
	endfunction

	// Called and returns at a falling edge; valid stays high between
	// back-to-back beats.
	task automatic send_beat(cmd_beat_t b);
		if (!calm && $urandom_range(99) < 15) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < 15)
				@(negedge clk);
		end
		cmd <= b;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		pending_results.push_back(ring_predict(b));
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_packet(int len);
		send_beat(hdr_beat(len, {$urandom(), $urandom()}));
		for (int i = 0; i < len; i++)
			send_beat(data_beat(8'($urandom_range(255))));
	endtask

	task automatic test_directed();
		send_beat(peek_beat(0));
		send_beat(data_beat(8'hFF));
		send_beat(hdr_beat(0, '1));
		send_beat(hdr_beat(2047, '1));
		send_beat(hdr_beat(MAX_BYTES + 1, '0));
		send_beat(hdr_beat(MAX_BYTES, '0));
		send_beat(hdr_beat(3, '1));
		send_beat(data_beat(8'h00));
		send_beat(data_beat(8'hFF));
		send_beat(data_beat(8'hA5));
		send_beat(hdr_beat(2, '0));
		send_beat(data_beat(8'h11));
		send_beat(hdr_beat(MAX_BYTES + 1, 64'h0123_4567_89AB_CDEF));
		send_beat(data_beat(8'h22));
		send_beat(hdr_beat(4, 64'hDEAD_BEEF_0000_0001));
		send_beat(data_beat(8'h33));
		send_beat(hdr_beat(1, 64'h8000_0000_0000_0000));
		send_beat(data_beat(8'h44));
		send_beat(peek_beat(0));
		send_beat(peek_beat(2));
		send_beat(peek_beat(3));
		send_beat(peek_beat(2047));
		repeat (4)
			send_beat(pop_beat());
	endtask

	task automatic test_long_packet();
		calm = 1'b1;
		send_packet(200);
		send_beat(peek_beat(199));
		send_beat(peek_beat(200));
		send_beat(peek_beat(0));
		send_beat(pop_beat());
		calm = 1'b0;
	endtask

	task automatic test_ring_overflow();
		repeat (SLOTS + 6)
			send_packet($urandom_range(1, 2));
		send_beat(hdr_beat(2, {$urandom(), $urandom()}));
		send_beat(data_beat(8'($urandom_range(255))));
		send_beat(hdr_beat(1, {$urandom(), $urandom()}));
		send_beat(data_beat(8'($urandom_range(255))));
		send_beat(hdr_beat(3, {$urandom(), $urandom()}));
		while (held > 0) begin
			send_beat(peek_beat($urandom_range(slot_len[rd_ptr])));
			send_beat(pop_beat());
		end
	endtask

	task automatic test_response_stall();
		hold_req = 300;
		repeat (10) begin
			send_packet($urandom_range(1, 3));
			send_beat(peek_beat(0));
		end
		while (held > 0)
			send_beat(pop_beat());
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int roll;
		stop_at = beats_sent + 130;
		while (beats_sent < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				roll = $urandom_range(99);
				if (roll < 85)
					send_packet($urandom_range(1, 8));
				else if (roll < 97)
					send_packet($urandom_range(9, 64));
				else
					send_packet($urandom_range(65, 300));
			end else if (roll < 43) begin
				roll = $urandom_range(1, 8);
				send_beat(hdr_beat(roll, {$urandom(), $urandom()}));
				repeat ($urandom_range(roll - 1))
					send_beat(data_beat(8'($urandom_range(255))));
			end else if (roll < 68) begin
				if (held > 0 && $urandom_range(99) < 80)
					send_beat(peek_beat($urandom_range(slot_len[rd_ptr])));
				else
					send_beat(peek_beat($urandom_range(2047)));
			end else if (roll < 93) begin
				send_beat(pop_beat());
			end else begin
				send_beat(rand_beat());
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= calm || ($urandom_range(99) >= 15);
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		rsp_beat_t want;
		if (rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response beat %0h", $time, rsp);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.status), 64'(rsp.status));
				check_field("dropped_oldest", 64'(want.dropped_oldest),
					64'(rsp.dropped_oldest));
				check_field("read_byte", 64'(want.read_byte), 64'(rsp.read_byte));
				check_field("out_length", 64'(want.out_length), 64'(rsp.out_length));
				check_field("out_timestamp_us", want.out_timestamp_us,
					rsp.out_timestamp_us);
				check_field("drop_count", 64'(want.drop_count), 64'(rsp.drop_count));
				check_field("queued", 64'(want.queued), 64'(rsp.queued));
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_long_packet();
		test_ring_overflow();
		test_response_stall();
		test_random_traffic();
		cmd_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
